// ===== design/hamdec_pkg.sv =====
// Shared constants, types and the error-position table for the SECDED block decoder.
package hamdec_pkg;

    localparam int unsigned CW_W            = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned SYN_W           = 4;
    localparam int unsigned WORD_IDX_W      = 3;
    localparam int unsigned EXTRA_CNT_W     = 2;

    localparam logic [WORD_IDX_W-1:0]  LAST_WORD_IDX = 3'd7;
    localparam logic [EXTRA_CNT_W-1:0] EXTRA_BYTES   = 2'd3;

    localparam logic [CW_W-1:0] SYN_MASK0 = 16'hab61;
    localparam logic [CW_W-1:0] SYN_MASK1 = 16'hcda2;
    localparam logic [CW_W-1:0] SYN_MASK2 = 16'hf1c4;
    localparam logic [CW_W-1:0] SYN_MASK3 = 16'hfe08;

    typedef struct packed {
        logic [CW_W-1:0] corrected;
        logic            double_err;
    } hamdec_result_t;

    // Map a syndrome to the codeword bit that it names.
    function automatic logic [CW_W-1:0] flip_mask(input logic [SYN_W-1:0] syn);
        logic [CW_W-1:0] m;
        unique case (syn)
            4'd0:    m = 16'h0000;
            4'd1:    m = 16'h0001;
            4'd2:    m = 16'h0002;
            4'd3:    m = 16'h0020;
            4'd4:    m = 16'h0004;
            4'd5:    m = 16'h0040;
            4'd6:    m = 16'h0080;
            4'd7:    m = 16'h0100;
            4'd8:    m = 16'h0008;
            4'd9:    m = 16'h0200;
            4'd10:   m = 16'h0400;
            4'd11:   m = 16'h0800;
            4'd12:   m = 16'h1000;
            4'd13:   m = 16'h2000;
            4'd14:   m = 16'h4000;
            default: m = 16'h8000;
        endcase
        return m;
    endfunction

endpackage

// ===== design/hamdec_correct.sv =====
// Syndrome, overall parity and single-bit correction of one codeword.
module hamdec_correct
    import hamdec_pkg::*;
(
    input  logic [CW_W-1:0] codeword,
    output hamdec_result_t  result
);

    logic [SYN_W-1:0] syn;
    logic             overall;

    always_comb
    begin
        syn[0]  = ^(codeword & SYN_MASK0);
        syn[1]  = ^(codeword & SYN_MASK1);
        syn[2]  = ^(codeword & SYN_MASK2);
        syn[3]  = ^(codeword & SYN_MASK3);
        overall = ^codeword;
        // Nonzero syndrome with even parity: uncorrectable, flip anyway
        result.double_err = (syn != '0) && !overall;
        result.corrected  = codeword ^ flip_mask(syn);
    end

endmodule

// ===== design/hamming_16_11_secded_block_decoder_core.sv =====
// Top level of the extended Hamming(16,11) SECDED block decoder.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  input   | in_valid / in_ready   | codeword[15:0]
//  output  | out_valid / out_ready | data_byte[7:0], last_of_block, word_double_error,
//          |                      | block_ok
//
// A codeword is registered, decoded combinationally from that register and its high
// byte lands in the output register; one codeword a cycle is sustained while the output
// is not stalled and no gathered bytes are queued. The eighth codeword of a block adds
// three gathered bytes, which leave the output register on the next three output
// transactions; the decode stage stalls meanwhile, so eight codewords give eleven bytes.
// Reset (rst_n, async, active low) empties both registers and starts a new block.
// A stalled output holds its payload. The input register accepts while it is empty or
// its codeword advances: output register free or draining, no gathered bytes queued.
module hamming_16_11_secded_block_decoder_core
    import hamdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CW_W-1:0]   codeword,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_byte,
    output logic              last_of_block,
    output logic              word_double_error,
    output logic              block_ok
);

    logic                   s1_valid_reg, s1_valid_next;
    logic [CW_W-1:0]        s1_cw_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_derr_reg, out_derr_next;
    logic                   out_ok_reg, out_ok_next;
    logic [EXTRA_CNT_W-1:0] extra_cnt_reg, extra_cnt_next;
    logic [BYTE_W-1:0]      ex7_reg, ex7_next;
    logic [BYTE_W-1:0]      ex6_reg, ex6_next;
    logic [BYTE_W-1:0]      ex5_reg, ex5_next;
    logic [WORD_IDX_W-1:0]  word_idx_reg, word_idx_next;
    logic [BYTE_W-1:0]      g7_reg, g7_next;
    logic [BYTE_W-1:0]      g6_reg, g6_next;
    logic [BYTE_W-1:0]      g5_reg, g5_next;
    logic                   nfs_reg, nfs_next;

    hamdec_result_t         dec;
    logic                   out_take;
    logic                   s1_adv;
    logic                   in_take;
    logic                   ok_now;
    logic [BYTE_W-1:0]      g7_shift, g6_shift, g5_shift;

    hamdec_correct u_correct
    (
        .codeword (s1_cw_reg),
        .result   (dec)
    );

    assign out_take = out_valid_reg && out_ready;
    // Advance the decode stage only when the output slot frees up and no gathered
    // bytes are still queued.
    assign s1_adv   = s1_valid_reg && (extra_cnt_reg == '0) && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    assign ok_now   = nfs_reg && !dec.double_err;
    assign g7_shift = {g7_reg[BYTE_W-2:0], dec.corrected[7]};
    assign g6_shift = {g6_reg[BYTE_W-2:0], dec.corrected[6]};
    assign g5_shift = {g5_reg[BYTE_W-2:0], dec.corrected[5]};

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_derr_next  = out_derr_reg;
        out_ok_next    = out_ok_reg;
        extra_cnt_next = extra_cnt_reg;
        ex7_next       = ex7_reg;
        ex6_next       = ex6_reg;
        ex5_next       = ex5_reg;
        word_idx_next  = word_idx_reg;
        g7_next        = g7_reg;
        g6_next        = g6_reg;
        g5_next        = g5_reg;
        nfs_next       = nfs_reg;

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            out_data_next  = dec.corrected[CW_W-1:BYTE_W];
            out_last_next  = 1'b0;
            out_derr_next  = dec.double_err;
            out_ok_next    = ok_now;
            if (word_idx_reg == LAST_WORD_IDX)
            begin
                // Queue the gathered bytes and start a fresh block
                ex7_next       = g7_shift;
                ex6_next       = g6_shift;
                ex5_next       = g5_shift;
                extra_cnt_next = EXTRA_BYTES;
                word_idx_next  = '0;
                g7_next        = '0;
                g6_next        = '0;
                g5_next        = '0;
                nfs_next       = 1'b1;
            end
            else
            begin
                word_idx_next = word_idx_reg + 1'b1;
                g7_next       = g7_shift;
                g6_next       = g6_shift;
                g5_next       = g5_shift;
                nfs_next      = ok_now;
            end
        end
        else if (out_take)
        begin
            if (extra_cnt_reg != '0)
            begin
                // Drop the sent byte and advance the gathered queue
                out_data_next  = ex7_reg;
                ex7_next       = ex6_reg;
                ex6_next       = ex5_reg;
                out_last_next  = (extra_cnt_reg == 2'd1);
                extra_cnt_next = extra_cnt_reg - 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            extra_cnt_reg <= '0;
            word_idx_reg  <= '0;
            g7_reg        <= '0;
            g6_reg        <= '0;
            g5_reg        <= '0;
            nfs_reg       <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            extra_cnt_reg <= extra_cnt_next;
            word_idx_reg  <= word_idx_next;
            g7_reg        <= g7_next;
            g6_reg        <= g6_next;
            g5_reg        <= g5_next;
            nfs_reg       <= nfs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cw_reg <= codeword;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_derr_reg <= out_derr_next;
        out_ok_reg   <= out_ok_next;
        ex7_reg      <= ex7_next;
        ex6_reg      <= ex6_next;
        ex5_reg      <= ex5_next;
    end

    assign out_valid         = out_valid_reg;
    assign data_byte         = out_data_reg;
    assign last_of_block     = out_last_reg;
    assign word_double_error = out_derr_reg;
    assign block_ok          = out_ok_reg;

endmodule
